FILE: rtl/mpoc_pkg.sv
// Shared types and constants of the multi-pattern occurrence counter.
// No dependencies; every other file of the block imports this package.
package mpoc_pkg;

    localparam int BYTE_W    = 8;
    localparam int PATTERN_W = 64;
    localparam int LENGTH_W  = 4;
    localparam int TOTAL_W   = 16;
    localparam int CFG_IDX_W = 3;

    typedef logic [BYTE_W-1:0]    byte_t;
    typedef logic [PATTERN_W-1:0] pattern_t;
    typedef logic [LENGTH_W-1:0]  length_t;
    typedef logic [TOTAL_W-1:0]   total_t;
    typedef logic [CFG_IDX_W-1:0] cfg_index_t;

    // Register indexes of the configuration port.
    localparam cfg_index_t CFG_PATTERN_A = 3'd0;
    localparam cfg_index_t CFG_PATTERN_B = 3'd1;
    localparam cfg_index_t CFG_PATTERN_C = 3'd2;
    localparam cfg_index_t CFG_PATTERN_D = 3'd3;
    localparam cfg_index_t CFG_LENGTH_A  = 3'd4;
    localparam cfg_index_t CFG_LENGTH_B  = 3'd5;
    localparam cfg_index_t CFG_LENGTH_C  = 3'd6;
    localparam cfg_index_t CFG_LENGTH_D  = 3'd7;

    localparam total_t TOTAL_MAX = 16'hFFFF;

    typedef struct packed {
        byte_t text_byte;
        logic  end_of_text;
    } in_word_t;

    typedef struct packed {
        total_t match_total;
        logic   total_saturated;
    } out_word_t;

    // Control that every cell of the window chain sees.
    typedef struct packed {
        logic shift;
        logic clear;
    } chain_ctrl_t;

endpackage

FILE: rtl/mpoc_cell.sv
// One cell of the byte window chain: holds one recent byte with its valid bit,
// and extends the per-pattern match chain. Depends on mpoc_pkg.
module mpoc_cell #(
    parameter int PATTERN_COUNT = 4,
    parameter int CELL_INDEX    = 0
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  mpoc_pkg::chain_ctrl_t        ctrl,
    input  mpoc_pkg::byte_t              byte_in,
    input  logic                         valid_in,
    input  mpoc_pkg::pattern_t           pattern [PATTERN_COUNT],
    input  mpoc_pkg::length_t            eff_len [PATTERN_COUNT],
    input  logic [PATTERN_COUNT-1:0]     match_in,
    output mpoc_pkg::byte_t              byte_out,
    output logic                         valid_out,
    output logic [PATTERN_COUNT-1:0]     match_out
);
    import mpoc_pkg::*;

    localparam length_t CELL_POS = length_t'(CELL_INDEX);

    byte_t byte_reg;
    byte_t byte_next;
    logic  valid_reg;
    logic  valid_next;

    always_comb begin
        byte_next  = ctrl.shift ? byte_in : byte_reg;
        valid_next = valid_reg;
        if (ctrl.clear) begin
            valid_next = 1'b0;
        end else if (ctrl.shift) begin
            valid_next = valid_in;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // The compare looks at the byte that enters this cell now. A pattern of
    // length L checks pattern byte L-1-k in cell k; cells beyond it pass.
    always_comb begin
        length_t idx;
        byte_t   want;
        match_out = '0;
        for (int p = 0; p < PATTERN_COUNT; p++) begin
            idx  = eff_len[p] - CELL_POS - length_t'(1);
            want = pattern[p][{idx[2:0], 3'b000} +: BYTE_W];
            match_out[p] = match_in[p] &
                           ((eff_len[p] <= CELL_POS) | (valid_in & (byte_in == want)));
        end
    end

    assign byte_out  = byte_reg;
    assign valid_out = valid_reg;

endmodule

FILE: rtl/mpoc_result_buf.sv
// Two-entry result buffer: output register plus skid register, so the input
// side keeps taking words while a total waits. Depends on mpoc_pkg.
module mpoc_result_buf (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  mpoc_pkg::out_word_t push_word,
    output logic                full,
    output logic                m_valid,
    input  logic                m_ready,
    output mpoc_pkg::out_word_t m_data
);
    import mpoc_pkg::*;

    out_word_t out_word_reg;
    out_word_t out_word_next;
    logic      out_valid_reg;
    logic      out_valid_next;
    out_word_t skid_word_reg;
    out_word_t skid_word_next;
    logic      skid_valid_reg;
    logic      skid_valid_next;
    logic      pop;

    assign pop = out_valid_reg & m_ready;

    always_comb begin
        out_word_next   = out_word_reg;
        out_valid_next  = out_valid_reg;
        skid_word_next  = skid_word_reg;
        skid_valid_next = skid_valid_reg;
        if (!out_valid_reg || pop) begin
            if (skid_valid_reg) begin
                out_word_next   = skid_word_reg;
                out_valid_next  = 1'b1;
                skid_word_next  = push_word;
                skid_valid_next = push;
            end else begin
                out_word_next  = push_word;
                out_valid_next = push;
            end
        end else if (push) begin
            skid_word_next  = push_word;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        out_word_reg  <= out_word_next;
        skid_word_reg <= skid_word_next;
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    assign full    = skid_valid_reg;
    assign m_valid = out_valid_reg;
    assign m_data  = out_word_reg;

endmodule

FILE: rtl/multi_pattern_occurrence_counter.sv
// Top level of the multi-pattern occurrence counter: configuration registers,
// the window chain of mpoc_cell, the running total and mpoc_result_buf.
// Depends on mpoc_pkg, mpoc_cell and mpoc_result_buf.
//
// The block takes one text byte per cycle while s_ready is high and, for
// each of up to PATTERN_COUNT patterns (1 to MAX_PATTERN_LEN bytes, length
// zero disables a pattern, lengths above the maximum act as the maximum),
// counts every position where it ends. Overlapping matches count and matches
// never span sentences. The byte window is a chain of MAX_PATTERN_LEN cells;
// the new byte is compared against all patterns in the cycle it is accepted,
// and the total is updated in that same cycle. On the word flagged
// end_of_text the total, saturated at 65535 with a flag, is pushed into a
// two-entry result buffer and the count restarts. s_ready drops only while
// both result entries are full. The user must write configuration through
// cfg_we/cfg_index/cfg_data while the block is idle; it does not check this.
module multi_pattern_occurrence_counter #(
    parameter int PATTERN_COUNT   = 4,
    parameter int MAX_PATTERN_LEN = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  mpoc_pkg::cfg_index_t  cfg_index,
    input  mpoc_pkg::pattern_t    cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  mpoc_pkg::in_word_t    s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output mpoc_pkg::out_word_t   m_data
);
    import mpoc_pkg::*;

    localparam int CNT_W = $clog2(PATTERN_COUNT + 1);

    pattern_t pattern_reg [PATTERN_COUNT];
    length_t  length_reg  [PATTERN_COUNT];
    length_t  eff_len     [PATTERN_COUNT];

    always_ff @(posedge aclk) begin
        for (int p = 0; p < PATTERN_COUNT; p++) begin
            if (!aresetn) begin
                pattern_reg[p] <= '0;
                length_reg[p]  <= '0;
            end else if (cfg_we) begin
                if (cfg_index == CFG_PATTERN_A + cfg_index_t'(p)) begin
                    pattern_reg[p] <= cfg_data;
                end
                if (cfg_index == CFG_LENGTH_A + cfg_index_t'(p)) begin
                    length_reg[p] <= cfg_data[LENGTH_W-1:0];
                end
            end
        end
    end

    always_comb begin
        for (int p = 0; p < PATTERN_COUNT; p++) begin
            eff_len[p] = (length_reg[p] > length_t'(MAX_PATTERN_LEN)) ?
                         length_t'(MAX_PATTERN_LEN) : length_reg[p];
        end
    end

    logic        s_fire;
    logic        buf_full;
    chain_ctrl_t ctrl;

    assign s_ready    = ~buf_full;
    assign s_fire     = s_valid & s_ready;
    assign ctrl.shift = s_fire;
    assign ctrl.clear = s_fire & s_data.end_of_text;

    byte_t                    byte_link  [MAX_PATTERN_LEN];
    logic                     valid_link [MAX_PATTERN_LEN];
    logic [PATTERN_COUNT-1:0] match_link [MAX_PATTERN_LEN+1];

    assign byte_link[0]  = s_data.text_byte;
    assign valid_link[0] = 1'b1;

    always_comb begin
        for (int p = 0; p < PATTERN_COUNT; p++) begin
            match_link[0][p] = (eff_len[p] != '0);
        end
    end

    for (genvar k = 0; k < MAX_PATTERN_LEN; k++) begin : g_cell
        if (k < MAX_PATTERN_LEN - 1) begin : g_mid
            mpoc_cell #(
                .PATTERN_COUNT (PATTERN_COUNT),
                .CELL_INDEX    (k)
            ) u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .ctrl      (ctrl),
                .byte_in   (byte_link[k]),
                .valid_in  (valid_link[k]),
                .pattern   (pattern_reg),
                .eff_len   (eff_len),
                .match_in  (match_link[k]),
                .byte_out  (byte_link[k+1]),
                .valid_out (valid_link[k+1]),
                .match_out (match_link[k+1])
            );
        end else begin : g_last
            mpoc_cell #(
                .PATTERN_COUNT (PATTERN_COUNT),
                .CELL_INDEX    (k)
            ) u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .ctrl      (ctrl),
                .byte_in   (byte_link[k]),
                .valid_in  (valid_link[k]),
                .pattern   (pattern_reg),
                .eff_len   (eff_len),
                .match_in  (match_link[k]),
                .byte_out  (),
                .valid_out (),
                .match_out (match_link[k+1])
            );
        end
    end

    total_t               total_reg;
    total_t               total_next;
    logic                 sat_reg;
    logic                 sat_next;
    logic [CNT_W-1:0]     hit_count;
    logic [TOTAL_W:0]     sum;
    total_t               sum_total;
    logic                 sum_sat;
    out_word_t            result_word;

    always_comb begin
        hit_count = '0;
        for (int p = 0; p < PATTERN_COUNT; p++) begin
            hit_count = hit_count + CNT_W'(match_link[MAX_PATTERN_LEN][p]);
        end
        sum       = {1'b0, total_reg} + (TOTAL_W+1)'(hit_count);
        sum_total = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
        sum_sat   = sat_reg | sum[TOTAL_W];

        total_next = total_reg;
        sat_next   = sat_reg;
        if (ctrl.clear) begin
            total_next = '0;
            sat_next   = 1'b0;
        end else if (s_fire) begin
            total_next = sum_total;
            sat_next   = sum_sat;
        end

        result_word.match_total     = sum_total;
        result_word.total_saturated = sum_sat;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg <= '0;
            sat_reg   <= 1'b0;
        end else begin
            total_reg <= total_next;
            sat_reg   <= sat_next;
        end
    end

    mpoc_result_buf u_result_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (ctrl.clear),
        .push_word (result_word),
        .full      (buf_full),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

`ifndef NO_ASSERTIONS
    // The count restarts after the last word of a sentence.
    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && s_data.end_of_text |=> total_reg == '0 && !sat_reg)
        else $error("running total not cleared after last word");

    // The flag is only ever set together with a pinned total.
    a_sat_pinned: assert property (@(posedge aclk) disable iff (!aresetn)
        sat_reg |-> total_reg == TOTAL_MAX)
        else $error("saturation flag set without full total");

    // Within a sentence the total never goes down.
    a_total_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && !s_data.end_of_text |=> total_reg >= $past(total_reg))
        else $error("running total decreased within a sentence");

    // An emitted result carries the flag only with a saturated total.
    a_result_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.total_saturated |-> m_data.match_total == TOTAL_MAX)
        else $error("result flagged saturated without full total");
`endif

endmodule

FILE: sim/mpoc_count_checker.sv
// Checker of the multi-pattern occurrence counter: watches the configuration
// port and both word channels, predicts every sentence total and compares.
// Depends on mpoc_pkg for the register indexes and the word types.
module mpoc_count_checker
    import mpoc_pkg::*;
#(
    parameter int PATTERN_COUNT   = 4,
    parameter int MAX_PATTERN_LEN = 8
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  cfg_index_t cfg_index,
    input  pattern_t   cfg_data,
    input  logic       s_valid,
    input  logic       s_ready,
    input  in_word_t   s_data,
    input  logic       m_valid,
    input  logic       m_ready,
    input  out_word_t  m_data,
    output int         pending,
    output int         fail_count
);

    localparam int SLOTS = 4;

    pattern_t  pats [SLOTS];
    length_t   lens [SLOTS];
    byte_t     window [MAX_PATTERN_LEN];
    int        seen;
    total_t    total;
    logic      sat;
    out_word_t expected_totals [$];

    task automatic clear_sentence();
        for (int i = 0; i < MAX_PATTERN_LEN; i++) window[i] = '0;
        seen  = 0;
        total = '0;
        sat   = 1'b0;
    endtask

    // Shifts one text byte into the window and adds the hits that end on it.
    task automatic count_byte(in_word_t w);
        int unsigned sum;
        int          l;
        bit          hit;
        out_word_t   result;
        for (int i = MAX_PATTERN_LEN - 1; i > 0; i--) window[i] = window[i-1];
        window[0] = w.text_byte;
        if (seen < MAX_PATTERN_LEN) seen++;
        sum = total;
        for (int s = 0; s < PATTERN_COUNT && s < SLOTS; s++) begin
            l   = (lens[s] > MAX_PATTERN_LEN) ? MAX_PATTERN_LEN : int'(lens[s]);
            hit = (l != 0) && (seen >= l);
            for (int i = 0; i < l; i++) begin
                if (window[l-1-i] != pats[s][8*i +: 8]) hit = 1'b0;
            end
            if (hit) sum++;
        end
        if (sum > TOTAL_MAX) begin
            sum = TOTAL_MAX;
            sat = 1'b1;
        end
        total = sum[TOTAL_W-1:0];
        if (w.end_of_text) begin
            result.match_total     = total;
            result.total_saturated = sat;
            expected_totals.push_back(result);
            clear_sentence();
        end
    endtask

    task automatic compare_total(out_word_t got);
        out_word_t want;
        if (expected_totals.size() == 0) begin
            $error("match_total: expected none, actual %0d", got.match_total);
            fail_count++;
        end else begin
            want = expected_totals.pop_front();
            if (got.match_total !== want.match_total) begin
                $error("match_total: expected %0d, actual %0d",
                       want.match_total, got.match_total);
                fail_count++;
            end
            if (got.total_saturated !== want.total_saturated) begin
                $error("total_saturated: expected %0d, actual %0d",
                       want.total_saturated, got.total_saturated);
                fail_count++;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s < SLOTS; s++) begin
                pats[s] = '0;
                lens[s] = '0;
            end
            clear_sentence();
            expected_totals.delete();
            fail_count = 0;
        end else begin
            if (cfg_we) begin
                if (cfg_index >= CFG_LENGTH_A)
                    lens[cfg_index - CFG_LENGTH_A] = cfg_data[LENGTH_W-1:0];
                else
                    pats[cfg_index - CFG_PATTERN_A] = cfg_data;
            end
            if (m_valid && m_ready) compare_total(m_data);
            if (s_valid && s_ready) count_byte(s_data);
        end
        pending <= expected_totals.size();
    end

endmodule

FILE: sim/tb_multi_pattern_occurrence_counter.sv
// Testbench top of the multi-pattern occurrence counter: clock, reset, text
// stimulus, configuration phases, receiver stalls and the final verdict.
// Depends on mpoc_pkg, multi_pattern_occurrence_counter and mpoc_count_checker.
module tb_multi_pattern_occurrence_counter;
    import mpoc_pkg::*;

    localparam int    PATTERN_COUNT   = 4;
    localparam int    MAX_PATTERN_LEN = 8;
    localparam int    STUCK_LIMIT     = 5000;
    localparam int    HOLD_CYCLES     = 300;
    localparam int    PHASES          = 8;
    localparam int    PHASE_WORDS     = 88;
    localparam byte_t COMMA           = 8'h2C;
    localparam byte_t LETTER_A        = 8'h61;

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       cfg_we    = 1'b0;
    cfg_index_t cfg_index = '0;
    pattern_t   cfg_data  = '0;
    logic       s_valid   = 1'b0;
    logic       s_ready;
    in_word_t   s_data    = '0;
    logic       m_valid;
    logic       m_ready   = 1'b0;
    out_word_t  m_data;

    int   pending;
    int   fail_count;
    int   stuck_cycles = 0;
    int   items_sent   = 0;
    int   sender_idle_pct = 0;
    int   stall_pct    = 0;
    logic hold_start   = 1'b0;
    logic hold_used    = 1'b0;
    int   hold_left    = 0;

    pattern_t cur_pat [4];
    length_t  cur_len [4];
    byte_t    alphabet [3];
    byte_t    sentence [$];

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    multi_pattern_occurrence_counter #(
        .PATTERN_COUNT  (PATTERN_COUNT),
        .MAX_PATTERN_LEN(MAX_PATTERN_LEN)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    mpoc_count_checker #(
        .PATTERN_COUNT  (PATTERN_COUNT),
        .MAX_PATTERN_LEN(MAX_PATTERN_LEN)
    ) checker_i (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .pending   (pending),
        .fail_count(fail_count)
    );

    // Receiver: random stalls, plus one long hold-off on request.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            hold_left <= 0;
            hold_used <= 1'b0;
        end else if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_start && !hold_used) begin
            m_ready   <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_used <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("multi_pattern_occurrence_counter regression: fail");
            $finish;
        end
    end

    task automatic send_word(byte_t b, logic last);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{text_byte: b, end_of_text: last};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic send_sentence();
        for (int i = 0; i < sentence.size(); i++)
            send_word(sentence[i], i == sentence.size() - 1);
        sentence.delete();
    endtask

    // Waits until every expected total has come back, then lets the block settle.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_config();
        for (int s = 0; s < 4; s++) begin
            cfg_we    <= 1'b1;
            cfg_index <= cfg_index_t'(CFG_PATTERN_A + s);
            cfg_data  <= cur_pat[s];
            @(posedge aclk);
        end
        // Upper bits of a length write carry junk that the block must drop.
        for (int s = 0; s < 4; s++) begin
            cfg_we    <= 1'b1;
            cfg_index <= cfg_index_t'(CFG_LENGTH_A + s);
            cfg_data  <= {$urandom(), 28'($urandom()), cur_len[s]};
            @(posedge aclk);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic random_config();
        int r;
        for (int i = 0; i < 3; i++) alphabet[i] = byte_t'($urandom_range(255));
        if ($urandom_range(99) < 20) alphabet[2] = COMMA;
        if ($urandom_range(99) < 20) alphabet[1] = 8'h00;
        for (int s = 0; s < 4; s++) begin
            r = $urandom_range(99);
            if (r < 10)      cur_len[s] = '0;
            else if (r < 20) cur_len[s] = length_t'($urandom_range(15, 9));
            else if (r < 35) cur_len[s] = length_t'(MAX_PATTERN_LEN);
            else             cur_len[s] = length_t'($urandom_range(MAX_PATTERN_LEN, 1));
            r = $urandom_range(99);
            if (r < 8)       cur_pat[s] = '1;
            else if (r < 12) cur_pat[s] = '0;
            else if (r < 20) cur_pat[s] = {$urandom(), $urandom()};
            else begin
                for (int i = 0; i < 8; i++)
                    cur_pat[s][8*i +: 8] = alphabet[$urandom_range(2)];
            end
        end
        if ($urandom_range(99) < 20) begin
            cur_pat[3] = cur_pat[0];
            cur_len[3] = cur_len[0];
        end
    endtask

    // Builds a sentence from the phase alphabet, planted patterns and noise bytes.
    task automatic random_sentence(int max_len);
        int n;
        int r;
        int s;
        int l;
        n = $urandom_range(max_len, 1);
        while (sentence.size() < n) begin
            r = $urandom_range(99);
            s = $urandom_range(3);
            l = (cur_len[s] > MAX_PATTERN_LEN) ? MAX_PATTERN_LEN : int'(cur_len[s]);
            if (r < 20 && l != 0) begin
                for (int i = 0; i < l; i++) sentence.push_back(cur_pat[s][8*i +: 8]);
            end else if (r < 35) begin
                sentence.push_back(byte_t'($urandom_range(255)));
            end else begin
                sentence.push_back(alphabet[$urandom_range(2)]);
            end
        end
        send_sentence();
    endtask

    initial begin
        int phase_end;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // All patterns disabled after reset: a single-byte sentence, then two bytes.
        sentence = '{8'h41};
        send_sentence();
        sentence = '{8'h41, 8'h00};
        send_sentence();
        drain();

        // Length above the maximum, a listed-twice comma and a zero-byte pattern.
        cur_pat = '{'1, pattern_t'(COMMA), '0, pattern_t'(COMMA)};
        cur_len = '{4'd15, 4'd1, 4'd2, 4'd1};
        write_config();
        sentence = '{8'h00};
        send_sentence();
        sentence = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                     COMMA, 8'h00, 8'h00};
        send_sentence();
        // Too short for the eight-byte pattern.
        sentence = '{8'hFF, 8'hFF, 8'hFF};
        send_sentence();
        drain();

        // Three hits per byte from one letter listed in three slots.
        cur_pat = '{pattern_t'(LETTER_A), pattern_t'(LETTER_A), pattern_t'(LETTER_A), '0};
        cur_len = '{4'd1, 4'd1, 4'd1, 4'd0};
        write_config();
        for (int k = 0; k < 2; k++) begin
            for (int i = 0; i < 12 + k; i++) sentence.push_back(LETTER_A);
            send_sentence();
        end
        drain();

        for (int p = 0; p < PHASES; p++) begin
            random_config();
            write_config();
            case (p % 4)
                0: begin sender_idle_pct = 0;  stall_pct <= 0;  end
                1: begin sender_idle_pct = 81; stall_pct <= 0;  end
                2: begin sender_idle_pct = 0;  stall_pct <= 81; end
                default: begin sender_idle_pct = 13; stall_pct <= 13; end
            endcase
            phase_end = items_sent + PHASE_WORDS;
            while (items_sent < phase_end)
                random_sentence(($urandom_range(99) < 10) ? 40 : 12);
            drain();
        end

        // Long receiver hold-off while short sentences keep coming.
        random_config();
        write_config();
        sender_idle_pct = 0;
        stall_pct  <= 0;
        hold_start <= 1'b1;
        phase_end = items_sent + 60;
        while (items_sent < phase_end) random_sentence(3);
        drain();

        if (fail_count == 0)
            $display("multi_pattern_occurrence_counter regression: pass");
        else
            $display("multi_pattern_occurrence_counter regression: fail");
        $finish;
    end

endmodule
